FILE: sv/tensor_slice_offset_stride_top_macros.svh
// Assertion macros for the tensor slice descriptor block.
// Included by the top level; the bodies vanish when SYNTHESIS is defined.
`ifndef TENSOR_SLICE_OFFSET_STRIDE_TOP_MACROS_SVH
`define TENSOR_SLICE_OFFSET_STRIDE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TSO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tso assertion failed");
`define TSO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tso assertion failed");
`else
`define TSO_ASSERT_IMP(lbl, ante, cons)
`define TSO_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: sv/tso_pkg.sv
// Shared widths, error codes and unit interface types of the tensor slice block.
// No dependencies; used by tso_iter_unit and tensor_slice_offset_stride_top.
`timescale 1ns / 1ps

package tso_pkg;

  localparam int SIZE_WIDTH   = 32;
  localparam int OFFSET_WIDTH = 48;
  localparam int STRIDE_WIDTH = 48;
  localparam int STEP_WIDTH   = 16;
  localparam int INDEX_WIDTH  = 33;

  localparam int CALC_WIDTH = ((SIZE_WIDTH > INDEX_WIDTH) ? SIZE_WIDTH : INDEX_WIDTH) + 2;
  localparam int ACC_WIDTH  = ((OFFSET_WIDTH > STRIDE_WIDTH) ? OFFSET_WIDTH : STRIDE_WIDTH) + 2;
  localparam int CNT_WIDTH  = $clog2(SIZE_WIDTH + 1);

  localparam int IN_DATA_WIDTH  = 216;
  localparam int IN_USER_WIDTH  = 4;
  localparam int OUT_DATA_WIDTH = 152;
  localparam int OUT_USER_WIDTH = 1;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_INDEX,
    ERR_ZERO_STEP,
    ERR_OVERFLOW
  } err_t;

  typedef struct packed {
    logic [SIZE_WIDTH-1:0]   dividend;
    logic [STEP_WIDTH-1:0]   divisor;
    logic [SIZE_WIDTH-1:0]   mult;
    logic [STRIDE_WIDTH-1:0] mag;
  } iter_load_t;

  typedef struct packed {
    logic [SIZE_WIDTH-1:0]   quo;
    logic [OFFSET_WIDTH-1:0] acc;
    logic                    ovf;
  } iter_res_t;

endpackage

FILE: sv/tensor_slice_offset_stride_top.sv
// Top level of the strided tensor slice descriptor block: handshake, sequencer, run state.
// Depends on tso_pkg, tso_iter_unit and tensor_slice_offset_stride_top_macros.svh.
//
// Usage: one request on the in_ channel describes one tensor dimension and its selector
// (integer index or slice); the out_ channel returns one result per request: kept flag,
// new size, new stride, running element offset and the sticky error code of the run.
// A request with in_tlast set closes the run; the next request starts a new run and
// loads base_offset. Errors stay latched for the rest of the run and freeze the offset.
// Each request passes through the normalize, load, iterate and finish steps; the
// result is registered in the output register, and a new request is accepted only
// after the finish step returns to idle. The shared divide and multiply unit runs one
// quotient bit and one offset product bit per cycle.
// in_tready is high only while no request is in work. A finished result sits in the
// output register, so the next request is taken and worked on while the receiver
// stalls; it then waits in the finish step until the output register frees up.
// Reset (rst_n low, synchronous) drops any request in work, clears out_tvalid, sets the
// running offset and error to zero and marks the next request as a run start.
`timescale 1ns / 1ps
`include "tensor_slice_offset_stride_top_macros.svh"

module tensor_slice_offset_stride_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // ext_size[31:0], elem_stride[79:32], start_req[112:80], stop[145:113], step[161:146],
  // base_offset[209:162], zero pad [215:210]
  input  logic [tso_pkg::IN_DATA_WIDTH-1:0]   in_tdata,
  // is_index[0], has_start[1], has_stop[2], has_step[3]
  input  logic [tso_pkg::IN_USER_WIDTH-1:0]   in_tuser,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // new_size[31:0], new_stride[95:32], offset[143:96], error_code[145:144],
  // zero pad [151:146]
  output logic [tso_pkg::OUT_DATA_WIDTH-1:0]  out_tdata,
  // keeps_dim[0]
  output logic [tso_pkg::OUT_USER_WIDTH-1:0]  out_tuser,
  output logic                                out_tlast
);

  localparam int SW  = tso_pkg::SIZE_WIDTH;
  localparam int OW  = tso_pkg::OFFSET_WIDTH;
  localparam int CW  = tso_pkg::CALC_WIDTH;
  localparam int STW = tso_pkg::STEP_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_LOAD,
    S_ITER,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  // request fields
  logic [SW-1:0]        size_r;
  logic signed [47:0]   stride_r;
  logic                 is_index_r;
  logic signed [32:0]   start_r;
  logic                 has_start_r;
  logic signed [32:0]   stop_r;
  logic                 has_stop_r;
  logic signed [15:0]   step_r;
  logic                 has_step_r;
  logic                 last_r;

  // bound normalization results
  logic signed [CW-1:0] st_c_r, sp_c_r;
  logic                 idx_bad_r;
  logic                 step_neg_r, step_zero_r;
  logic [STW-1:0]       abs_step_r;
  logic signed [STW:0]  step_v_r;

  // load step results
  logic                 nonempty_r;
  logic signed [63:0]   nstride_r;
  logic                 neg_stride_r;

  // run state and sequencing
  logic [OW-1:0]                  run_off_r, run_off_nxt;
  tso_pkg::err_t                  run_err_r, run_err_nxt;
  logic                           at_start_r, at_start_nxt;
  logic [tso_pkg::CNT_WIDTH-1:0]  cnt_r, cnt_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic          out_keeps_r, out_keeps_nxt;
  logic [31:0]   out_size_r, out_size_nxt;
  logic [63:0]   out_stride_r, out_stride_nxt;
  logic [47:0]   out_off_r, out_off_nxt;
  tso_pkg::err_t out_err_r, out_err_nxt;
  logic          out_last_r, out_last_nxt;

  logic in_acc;
  logic out_free;

  tso_pkg::iter_load_t unit_ld;
  tso_pkg::iter_res_t  unit_res;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // ---- normalization ----
  logic signed [CW-1:0] size_s, start_s, stop_s, st_adj, sp_adj;
  logic signed [CW-1:0] lower, upper, st_cl, sp_cl, start_c, stop_c;
  logic signed [STW:0]  step_v;
  logic                 neg_c, zero_c;
  logic [STW-1:0]       abs_c;
  logic                 idx_bad_c;

  always_comb begin
    size_s  = signed'(CW'(size_r));
    start_s = CW'(start_r);
    stop_s  = CW'(stop_r);
    st_adj  = start_s[CW-1] ? start_s + size_s : start_s;
    sp_adj  = stop_s[CW-1] ? stop_s + size_s : stop_s;
    step_v  = has_step_r ? (STW+1)'(step_r) : (STW+1)'(1);
    neg_c   = step_v[STW];
    zero_c  = (step_v == '0);
    abs_c   = neg_c ? STW'(-step_v) : STW'(step_v);
    lower   = neg_c ? {CW{1'b1}} : {CW{1'b0}};
    upper   = neg_c ? size_s - CW'(1) : size_s;
    if (st_adj < lower) begin
      st_cl = lower;
    end else if (st_adj > upper) begin
      st_cl = upper;
    end else begin
      st_cl = st_adj;
    end
    if (sp_adj < lower) begin
      sp_cl = lower;
    end else if (sp_adj > upper) begin
      sp_cl = upper;
    end else begin
      sp_cl = sp_adj;
    end
    start_c   = has_start_r ? st_cl : (neg_c ? upper : lower);
    stop_c    = has_stop_r ? sp_cl : (neg_c ? lower : upper);
    idx_bad_c = st_adj[CW-1] || (st_adj >= size_s);
  end

  // ---- load of the shared unit ----
  logic signed [CW-1:0] dist_m1;
  logic                 nonempty_c;
  logic signed [63:0]   nstride_c;

  always_comb begin
    nonempty_c = !is_index_r && !step_zero_r
              && (step_neg_r ? (sp_c_r < st_c_r) : (st_c_r < sp_c_r));
    dist_m1    = step_neg_r ? st_c_r - sp_c_r - CW'(1) : sp_c_r - st_c_r - CW'(1);
    nstride_c  = 64'(stride_r) * 64'(step_v_r);
    unit_ld.dividend = dist_m1[SW-1:0];
    unit_ld.divisor  = abs_step_r;
    unit_ld.mult     = st_c_r[SW-1:0];
    unit_ld.mag      = stride_r[47] ? 48'(-stride_r) : 48'(stride_r);
  end

  tso_iter_unit u_iter (
    .clk  (clk),
    .load (state_r == S_LOAD),
    .step (state_r == S_ITER),
    .ld   (unit_ld),
    .res  (unit_res)
  );

  // ---- finish ----
  logic [SW:0]       len_c;
  logic [OW:0]       off_sum;
  logic [OW-1:0]     off_diff, new_off;
  logic              over;
  logic              move;
  tso_pkg::err_t     err_c;

  always_comb begin
    len_c    = nonempty_r ? (SW+1)'(unit_res.quo) + (SW+1)'(1) : '0;
    off_sum  = {1'b0, run_off_r} + {1'b0, unit_res.acc};
    off_diff = run_off_r - unit_res.acc;
    if (neg_stride_r) begin
      over    = unit_res.ovf || (unit_res.acc > run_off_r);
      new_off = off_diff;
    end else begin
      over    = unit_res.ovf || off_sum[OW];
      new_off = off_sum[OW-1:0];
    end
    err_c = tso_pkg::ERR_NONE;
    move  = 1'b0;
    if (is_index_r) begin
      if (idx_bad_r) begin
        err_c = tso_pkg::ERR_INDEX;
      end else if (over) begin
        err_c = tso_pkg::ERR_OVERFLOW;
      end else begin
        move = 1'b1;
      end
    end else if (step_zero_r) begin
      err_c = tso_pkg::ERR_ZERO_STEP;
    end else if (nonempty_r) begin
      if (over) begin
        err_c = tso_pkg::ERR_OVERFLOW;
      end else begin
        move = 1'b1;
      end
    end
  end

  // ---- sequencer ----
  always_comb begin
    state_nxt      = state_r;
    run_off_nxt    = run_off_r;
    run_err_nxt    = run_err_r;
    at_start_nxt   = at_start_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    out_keeps_nxt  = out_keeps_r;
    out_size_nxt   = out_size_r;
    out_stride_nxt = out_stride_r;
    out_off_nxt    = out_off_r;
    out_err_nxt    = out_err_r;
    out_last_nxt   = out_last_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (at_start_r) begin
            run_off_nxt = OW'(in_tdata[209:162]);
            run_err_nxt = tso_pkg::ERR_NONE;
          end
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cnt_nxt   = tso_pkg::CNT_WIDTH'(SW);
        state_nxt = S_ITER;
      end
      S_ITER: begin
        cnt_nxt = cnt_r - tso_pkg::CNT_WIDTH'(1);
        if (cnt_r == tso_pkg::CNT_WIDTH'(1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          if (run_err_r == tso_pkg::ERR_NONE) begin
            if (err_c != tso_pkg::ERR_NONE) begin
              run_err_nxt = err_c;
            end else if (move) begin
              run_off_nxt = new_off;
            end
          end
          at_start_nxt   = last_r;
          out_valid_nxt  = 1'b1;
          out_keeps_nxt  = !is_index_r;
          out_size_nxt   = 32'(len_c);
          out_stride_nxt = (is_index_r || step_zero_r) ? 64'd0 : nstride_r;
          out_off_nxt    = 48'(run_off_nxt);
          out_err_nxt    = run_err_nxt;
          out_last_nxt   = last_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      run_off_r    <= '0;
      run_err_r    <= tso_pkg::ERR_NONE;
      at_start_r   <= 1'b1;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      out_keeps_r  <= 1'b0;
      out_size_r   <= '0;
      out_stride_r <= '0;
      out_off_r    <= '0;
      out_err_r    <= tso_pkg::ERR_NONE;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      run_off_r    <= run_off_nxt;
      run_err_r    <= run_err_nxt;
      at_start_r   <= at_start_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      out_keeps_r  <= out_keeps_nxt;
      out_size_r   <= out_size_nxt;
      out_stride_r <= out_stride_nxt;
      out_off_r    <= out_off_nxt;
      out_err_r    <= out_err_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      size_r      <= SW'(in_tdata[31:0]);
      stride_r    <= in_tdata[79:32];
      start_r     <= in_tdata[112:80];
      stop_r      <= in_tdata[145:113];
      step_r      <= in_tdata[161:146];
      is_index_r  <= in_tuser[0];
      has_start_r <= in_tuser[1];
      has_stop_r  <= in_tuser[2];
      has_step_r  <= in_tuser[3];
      last_r      <= in_tlast;
    end
    if (state_r == S_NORM) begin
      st_c_r      <= is_index_r ? st_adj : start_c;
      sp_c_r      <= stop_c;
      idx_bad_r   <= idx_bad_c;
      step_neg_r  <= neg_c;
      step_zero_r <= zero_c;
      abs_step_r  <= abs_c;
      step_v_r    <= step_v;
    end
    if (state_r == S_LOAD) begin
      nonempty_r   <= nonempty_c;
      nstride_r    <= nstride_c;
      neg_stride_r <= stride_r[47];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_err_r, out_off_r, out_stride_r, out_size_r};
  assign out_tuser  = out_keeps_r;
  assign out_tlast  = out_last_r;

  `TSO_ASSERT_NEXT(a_busy_after_accept, (in_tvalid && in_tready), !in_tready)
  `TSO_ASSERT_IMP(a_index_result_empty, (out_tvalid && !out_tuser[0]), (out_tdata[95:0] == 96'd0))
  `TSO_ASSERT_NEXT(a_error_freezes_offset, ((run_err_r != tso_pkg::ERR_NONE) && !in_acc), $stable(run_off_r))

endmodule

FILE: sv/tso_iter_unit.sv
// Shared iterative unit: one restoring divide step and one shift-add multiply step per cycle while step is high.
// Depends on tso_pkg for widths and the load/result structs.
`timescale 1ns / 1ps

module tso_iter_unit (
  input  logic                clk,
  input  logic                load,
  input  logic                step,
  input  tso_pkg::iter_load_t ld,
  output tso_pkg::iter_res_t  res
);

  logic [tso_pkg::SIZE_WIDTH-1:0]   quo_r, quo_nxt;
  logic [tso_pkg::STEP_WIDTH-1:0]   rem_r, rem_nxt;
  logic [tso_pkg::STEP_WIDTH-1:0]   divisor_r;
  logic [tso_pkg::SIZE_WIDTH-1:0]   mult_r;
  logic [tso_pkg::STRIDE_WIDTH-1:0] mag_r;
  logic [tso_pkg::ACC_WIDTH-1:0]    acc_r, acc_nxt;
  logic                             ovf_r, ovf_nxt;

  logic [tso_pkg::STEP_WIDTH:0]   rem_sh;
  logic [tso_pkg::STEP_WIDTH+1:0] diff;
  logic                           take;

  always_comb begin
    rem_sh  = {rem_r, quo_r[tso_pkg::SIZE_WIDTH-1]};
    diff    = {1'b0, rem_sh} - (tso_pkg::STEP_WIDTH+2)'(divisor_r);
    take    = !diff[tso_pkg::STEP_WIDTH+1];
    rem_nxt = take ? diff[tso_pkg::STEP_WIDTH-1:0] : rem_sh[tso_pkg::STEP_WIDTH-1:0];
    quo_nxt = {quo_r[tso_pkg::SIZE_WIDTH-2:0], take};
    acc_nxt = {acc_r[tso_pkg::ACC_WIDTH-2:0], 1'b0}
            + (mult_r[tso_pkg::SIZE_WIDTH-1] ? tso_pkg::ACC_WIDTH'(mag_r)
                                             : {tso_pkg::ACC_WIDTH{1'b0}});
    ovf_nxt = ovf_r | (|acc_nxt[tso_pkg::ACC_WIDTH-1:tso_pkg::OFFSET_WIDTH]);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quo_r     <= ld.dividend;
      rem_r     <= '0;
      divisor_r <= ld.divisor;
      mult_r    <= ld.mult;
      mag_r     <= ld.mag;
      acc_r     <= '0;
      ovf_r     <= 1'b0;
    end else if (step) begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      mult_r <= {mult_r[tso_pkg::SIZE_WIDTH-2:0], 1'b0};
      acc_r  <= acc_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  assign res.quo = quo_r;
  assign res.acc = acc_r[tso_pkg::OFFSET_WIDTH-1:0];
  assign res.ovf = ovf_r;

endmodule

FILE: test/tb_tensor_slice_offset_stride_top.sv
// Self-checking bench for the strided tensor slice descriptor block: directed and random
// dimension requests in bursts, a stalling receiver and an in-bench slice/offset predictor.
// Depends on tso_pkg and tensor_slice_offset_stride_top.
`timescale 1ns / 1ps

module tb_tensor_slice_offset_stride_top;

  localparam longint IDX_MAX    = 64'sd4294967295;
  localparam longint IDX_MIN    = -64'sd4294967296;
  localparam longint STRIDE_MAX = 64'sd140737488355327;
  localparam longint STRIDE_MIN = -64'sd140737488355328;
  localparam logic [63:0] OFF_MAX = 64'h0000_FFFF_FFFF_FFFF;
  localparam int RANDOM_ITEMS = 1300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [31:0]        ext_size;
    logic signed [47:0] elem_stride;
    logic               is_index;
    logic signed [32:0] start_req;
    logic               has_start;
    logic signed [32:0] stop_pos;
    logic               has_stop;
    logic signed [15:0] step;
    logic               has_step;
    logic [47:0]        base_offset;
    logic               last_dim;
    bit                 hold_for_drain;
  } dim_req_t;

  typedef struct {
    logic          keeps_dim;
    logic [31:0]   new_size;
    logic [63:0]   new_stride;
    logic [47:0]   offset;
    tso_pkg::err_t error_code;
    logic          last_dim;
  } slice_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [tso_pkg::IN_DATA_WIDTH-1:0] in_tdata = '0;
  logic [tso_pkg::IN_USER_WIDTH-1:0] in_tuser = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [tso_pkg::OUT_DATA_WIDTH-1:0] out_tdata;
  logic [tso_pkg::OUT_USER_WIDTH-1:0] out_tuser;
  logic out_tlast;

  dim_req_t   pending_q[$];
  slice_res_t expected_q[$];
  dim_req_t   drive_req;
  slice_res_t want;
  slice_res_t got;
  int total_items = 0;
  int sent_count = 0;
  int result_count = 0;
  int mismatches = 0;
  int gap_left = 0;
  int burst_left = 8;
  int ready_mode = 0;
  int ready_left = 0;

  // slice predictor state
  logic [tso_pkg::OFFSET_WIDTH-1:0] cur_offset = '0;
  tso_pkg::err_t run_err = tso_pkg::ERR_NONE;
  bit   at_run_start = 1'b1;

  tensor_slice_offset_stride_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic longint near_range(input longint span);
    return longint'(rnd64() % (2 * span + 1)) - span;
  endfunction

  // off + k*s inside the offset range; 0 on overflow
  function automatic bit offset_move(input bit [63:0] off, input bit [63:0] k, input longint s,
                                     output bit [63:0] res);
    bit [63:0] top;
    bit [63:0] mag;
    top = (64'd1 << tso_pkg::OFFSET_WIDTH) - 1;
    res = off;
    if (s >= 0) begin
      mag = s;
      if (mag != 0 && k > (top - off) / mag) return 1'b0;
      res = off + k * mag;
    end else begin
      mag = -s;
      if (k > off / mag) return 1'b0;
      res = off - k * mag;
    end
    return 1'b1;
  endfunction

  function automatic slice_res_t predict_slice(input dim_req_t r);
    slice_res_t res;
    longint size, stride, first, stop_at, step, lower, upper, len;
    tso_pkg::err_t err;
    bit [63:0] moved;
    bit move;
    size = r.ext_size;
    stride = r.elem_stride;
    first = r.start_req;
    stop_at = r.stop_pos;
    step = r.has_step ? longint'(r.step) : 1;
    err = tso_pkg::ERR_NONE;
    move = 1'b0;
    moved = '0;
    res.keeps_dim = 1'b0;
    res.new_size = '0;
    res.new_stride = '0;
    if (at_run_start) begin
      cur_offset = r.base_offset;
      run_err = tso_pkg::ERR_NONE;
    end
    if (r.is_index) begin
      if (first < 0) first = first + size;
      if (first < 0 || first >= size) err = tso_pkg::ERR_INDEX;
      else if (!offset_move(cur_offset, first, stride, moved)) err = tso_pkg::ERR_OVERFLOW;
      else move = 1'b1;
    end else if (step == 0) begin
      res.keeps_dim = 1'b1;
      err = tso_pkg::ERR_ZERO_STEP;
    end else begin
      lower = (step > 0) ? 0 : -1;
      upper = (step > 0) ? size : size - 1;
      res.keeps_dim = 1'b1;
      if (!r.has_start) begin
        first = (step > 0) ? lower : upper;
      end else begin
        if (first < 0) first = first + size;
        if (first < lower) first = lower;
        else if (first > upper) first = upper;
      end
      if (!r.has_stop) begin
        stop_at = (step > 0) ? upper : lower;
      end else begin
        if (stop_at < 0) stop_at = stop_at + size;
        if (stop_at < lower) stop_at = lower;
        else if (stop_at > upper) stop_at = upper;
      end
      len = 0;
      if (step > 0 && first < stop_at) len = (stop_at - first - 1) / step + 1;
      else if (step < 0 && stop_at < first) len = (first - stop_at - 1) / (-step) + 1;
      res.new_size = len[31:0];
      res.new_stride = stride * step;
      if (len > 0) begin
        if (!offset_move(cur_offset, first, stride, moved)) err = tso_pkg::ERR_OVERFLOW;
        else move = 1'b1;
      end
    end
    if (run_err == tso_pkg::ERR_NONE) begin
      if (err != tso_pkg::ERR_NONE) run_err = err;
      else if (move) cur_offset = moved[tso_pkg::OFFSET_WIDTH-1:0];
    end
    res.offset = cur_offset;
    res.error_code = run_err;
    res.last_dim = r.last_dim;
    at_run_start = r.last_dim;
    return res;
  endfunction

  task automatic add_dim(input logic [31:0] size, input longint stride, input bit is_idx,
                         input longint start, input bit has_start, input longint stop_at,
                         input bit has_stop, input int step, input bit has_step,
                         input logic [63:0] base, input bit last_dim, input bit hold = 1'b0);
    dim_req_t r;
    r.ext_size = size;
    r.elem_stride = stride[47:0];
    r.is_index = is_idx;
    r.start_req = start[32:0];
    r.has_start = has_start;
    r.stop_pos = stop_at[32:0];
    r.has_stop = has_stop;
    r.step = step[15:0];
    r.has_step = has_step;
    r.base_offset = base[47:0];
    r.last_dim = last_dim;
    r.hold_for_drain = hold;
    pending_q.insert(pending_q.size(), r);
  endtask

  task automatic add_random_dim(input logic [63:0] base, input bit last_dim, input bit hold);
    logic [31:0] size;
    longint stride, first, stop_at, span;
    int step;
    bit is_idx;
    case ($urandom_range(0, 7))
      0, 1, 2: size = $urandom_range(0, 12);
      3, 4:    size = $urandom_range(0, 5000);
      6:       size = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 1));
      default: size = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0, 1, 2: stride = longint'(int'($urandom_range(0, 40)) - 20);
      3:       stride = longint'(rnd64());
      4:       stride = $urandom_range(0, 1) ? STRIDE_MAX : STRIDE_MIN;
      default: stride = longint'($urandom) * ($urandom_range(0, 1) ? 1 : -1);
    endcase
    span = longint'(size) + 3;
    is_idx = ($urandom_range(0, 2) == 0);
    first = near_range(span);
    stop_at = near_range(span);
    if (is_idx && size != 0 && $urandom_range(0, 4) != 0) begin
      first = $urandom_range(0, size - 1);
      if ($urandom_range(0, 1)) first = first - longint'(size);
    end
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5:        step = 1;
      6, 7, 8, 9, 10, 11:      step = $urandom_range(1, 7);
      12, 13, 14, 15, 16:      step = -int'($urandom_range(1, 7));
      17, 18:                  step = int'($urandom_range(0, 65535)) - 32768;
      default:                 step = 0;
    endcase
    add_dim(size, stride, is_idx, first, $urandom_range(0, 3) != 0, stop_at,
            $urandom_range(0, 3) != 0, step, $urandom_range(0, 4) != 0, base, last_dim, hold);
  endtask

  // stimulus, then drain and verdict
  initial begin
    int added;
    int ndims;
    logic [63:0] run_base;
    bit first_run;
    add_dim(5, 3, 1, 2, 0, 0, 0, 0, 0, 100, 0);
    add_dim(4, -2, 1, -1, 0, 0, 0, 0, 0, 0, 0);
    add_dim(6, 7, 0, 1, 1, 6, 1, 2, 1, 0, 0);
    add_dim(3, 1, 1, 3, 0, 0, 0, 0, 0, 0, 0);
    add_dim(8, 2, 0, 0, 1, 10, 1, 3, 1, 0, 1);
    add_dim(10, 1, 0, 0, 0, 0, 0, 0, 0, OFF_MAX, 0);
    add_dim(10, 1, 1, 1, 0, 0, 0, 0, 0, 0, 1);
    add_dim(5, 4, 0, 0, 0, 0, 0, 0, 1, 0, 1);
    add_dim(7, 5, 0, 0, 0, 0, 0, -1, 1, 0, 0);
    add_dim(10, 1, 0, -1, 1, -100, 1, -3, 1, 0, 0);
    add_dim(10, 3, 0, 5, 1, 2, 1, 1, 1, 0, 0);
    add_dim(0, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_dim(12, 1, 0, 0, 1, 10, 1, 7, 0, 0, 0);
    add_dim(10, 2, 0, -3, 1, 0, 0, 1, 1, 0, 0);
    add_dim(100, -1, 0, IDX_MIN, 1, IDX_MAX, 1, 32767, 1, 0, 0);
    add_dim(100, 1, 0, IDX_MAX, 1, IDX_MIN, 1, -32768, 1, 0, 1);
    add_dim(32'hFFFF_FFFF, STRIDE_MAX, 1, IDX_MAX - 1, 0, 0, 0, 0, 0, 0, 1);
    add_dim(2, STRIDE_MIN, 1, 1, 0, 0, 0, 0, 0, 5, 1);
    add_dim(32'hFFFF_FFFF, 1, 1, IDX_MIN, 0, 0, 0, 0, 0, 0, 0);
    add_dim(32'hFFFF_FFFF, 1, 1, IDX_MAX, 0, 0, 0, 0, 0, 0, 1);
    add_dim(32'hFFFF_FFFF, STRIDE_MIN, 0, 0, 0, 0, 0, -32768, 1, OFF_MAX, 1);
    add_dim(32'hFFFF_FFFF, STRIDE_MAX, 0, 0, 0, 0, 0, 32767, 1, 0, 1);
    add_dim(20, 1, 0, 0, 1, 10, 1, 3, 1, 0, 1);
    added = 0;
    first_run = 1'b1;
    while (added < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        add_dim($urandom, longint'(rnd64()), $urandom_range(0, 1), longint'(rnd64()),
                $urandom_range(0, 1), longint'(rnd64()), $urandom_range(0, 1),
                int'($urandom), $urandom_range(0, 1), rnd64(), $urandom_range(0, 1));
        added++;
      end else begin
        ndims = $urandom_range(1, 6);
        case ($urandom_range(0, 2))
          0:       run_base = $urandom_range(0, 100000);
          1:       run_base = rnd64();
          default: run_base = OFF_MAX - $urandom_range(0, 1000);
        endcase
        for (int k = 0; k < ndims; k++) begin
          add_random_dim((k == 0) ? run_base : rnd64(), k == ndims - 1,
                         k == 0 && (first_run || $urandom_range(0, 49) == 0));
        end
        first_run = 1'b0;
        added += ndims;
      end
    end
    total_items = pending_q.size();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (sent_count < total_items || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // request driver: bursts with random gaps, optional hold until drained
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_q.insert(expected_q.size(), predict_slice(drive_req));
        sent_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].hold_for_drain && expected_q.size() != 0)) begin
          drive_req = pending_q.pop_front();
          in_tdata <= {6'd0, drive_req.base_offset, drive_req.step, drive_req.stop_pos,
                       drive_req.start_req, drive_req.elem_stride, drive_req.ext_size};
          in_tuser <= {drive_req.has_step, drive_req.has_stop, drive_req.has_start,
                       drive_req.is_index};
          in_tlast <= drive_req.last_dim;
          in_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            case ($urandom_range(0, 3))
              0, 1: gap_left = 0;
              2:    gap_left = $urandom_range(1, 4);
              default: gap_left = $urandom_range(5, 60);
            endcase
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.keeps_dim = out_tuser[0];
      got.new_size = out_tdata[31:0];
      got.new_stride = out_tdata[95:32];
      got.offset = out_tdata[143:96];
      got.error_code = tso_pkg::err_t'(out_tdata[145:144]);
      got.last_dim = out_tlast;
      result_count++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with no request pending", result_count);
      end else begin
        want = expected_q.pop_front();
        if (got.keeps_dim !== want.keeps_dim || got.new_size !== want.new_size ||
            got.new_stride !== want.new_stride || got.offset !== want.offset ||
            got.error_code !== want.error_code || got.last_dim !== want.last_dim) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d expected keep=%0b size=%0d stride=%h off=%h err=%0d last=%0b",
                     result_count, want.keeps_dim, want.new_size, want.new_stride,
                     want.offset, want.error_code, want.last_dim);
            $display("result %0d got      keep=%0b size=%0d stride=%h off=%h err=%0d last=%0b",
                     result_count, got.keeps_dim, got.new_size, got.new_stride,
                     got.offset, got.error_code, got.last_dim);
          end
        end
      end
    end
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(20, 400);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= $urandom_range(0, 1);
      2:       out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= ($urandom_range(0, 59) == 0);
    endcase
  end

endmodule
